// ===== src/lzjb_pkg.sv =====
// ----------------------------------------------------------------------------
// lzjb_pkg
// Shared types and constants of the lzjb decompressor: field types, token
// phase, control states and the decode of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzjb_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [1:0]  count_type;
   typedef logic [15:0] word_type;

   // match token layout
   localparam int LEN_BITS = 6;
   localparam int OFF_BITS = 10;
   localparam int LEN_BIAS = 3;
   // longest match is 2**LEN_BITS - 1 + LEN_BIAS bytes
   localparam int RUN_W    = 7;

   localparam word_type OUT_LENGTH_RESET = 16'd2048;

   typedef logic [OFF_BITS-1:0] off_type;
   typedef logic [RUN_W-1:0]    run_type;

   // what the next source byte means
   typedef enum logic [1:0] {
      PH_CONTROL = 2'd0,
      PH_TOKEN   = 2'd1,
      PH_MATCH2  = 2'd2
   } phase_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_COPY = 2'd2
   } state_type;

   // what a held request does
   typedef enum logic [2:0] {
      EX_DROP    = 3'd0,
      EX_LIMIT   = 3'd1,
      EX_CONTROL = 3'd2,
      EX_MATCH1  = 3'd3,
      EX_LITERAL = 3'd4,
      EX_BADOFF  = 3'd5,
      EX_COPY    = 3'd6
   } exec_type;

endpackage

`default_nettype wire

// ===== src/lzjb_if.sv =====
// ----------------------------------------------------------------------------
// lzjb_if
// Valid/ready channels of the lzjb decompressor: compressed request bytes in,
// results of up to two decompressed bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lzjb_req_if;
   import lzjb_pkg::*;

   logic     valid;
   logic     ready;
   byte_type in_byte;
   logic     frame_start;

   modport source (output valid, output in_byte, output frame_start, input ready);
   modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

interface lzjb_rsp_if;
   import lzjb_pkg::*;

   logic      valid;
   logic      ready;
   byte_type  byte_a;
   byte_type  byte_b;
   count_type byte_count;
   logic      last_of_run;
   logic      frame_done;
   logic      frame_error;
   word_type  consumed_bytes;

   modport source (output valid, output byte_a, output byte_b, output byte_count,
                   output last_of_run, output frame_done, output frame_error,
                   output consumed_bytes, input ready);
   modport sink   (input valid, input byte_a, input byte_b, input byte_count,
                   input last_of_run, input frame_done, input frame_error,
                   input consumed_bytes, output ready);
endinterface

`default_nettype wire

// ===== src/lzjb_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// lzjb_decompressor_unit
// LZJB decompressor: one compressed byte per request, decoded against a
// history memory of the bytes produced in the current frame.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  req_chan  in   valid/ready        in_byte, frame_start
//  rsp_chan  out  valid/ready        byte_a, byte_b, byte_count, last_of_run,
//                                    frame_done, frame_error, consumed_bytes
//  csr_*     in   write enable       out_length
//
//  A request is taken in ST_IDLE and executed in ST_EXEC, where a full
//  result register can hold it. A match copy then runs in ST_COPY, bound
//  by the single history read port that returns one byte per cycle while
//  the result register can take it, with forwarding for a distance of one.
//  Reset clears control state only; the history needs no clearing pass.
//  A full result register holds the execute and copy stages in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzjb_decompressor_unit #(
   parameter int WINDOW_DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     reset,
   lzjb_req_if.sink                req_chan,
   lzjb_rsp_if.source              rsp_chan,
   input  wire                     csr_write_en,
   input  wire lzjb_pkg::word_type csr_write_data
);
   import lzjb_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   typedef logic [AW-1:0] ptr_type;

   // control registers
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   byte_type  ctrl_ff, ctrl_in;
   logic [2:0] bitpos_ff, bitpos_in;
   byte_type  mfb_ff, mfb_in;
   word_type  produced_ff, produced_in;
   word_type  consumed_ff, consumed_in;
   logic      over_ff, over_in;
   word_type  out_len_ff, out_len_in;
   ptr_type   wr_ptr_ff, wr_ptr_in;
   ptr_type   iss_ptr_ff, iss_ptr_in;
   run_type   iss_left_ff, iss_left_in;
   run_type   cnt_ff, cnt_in;
   logic      dv_ff, dv_in;
   logic      pair_full_ff, pair_full_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // payload registers
   byte_type  b_ff, b_in;
   off_type   off_ff, off_in;
   byte_type  pair_byte_ff, pair_byte_in;
   byte_type  mem_q_ff;
   logic      fwd_ff, fwd_in;
   byte_type  fwd_data_ff, fwd_data_in;
   byte_type  rsp_a_ff, rsp_a_in;
   byte_type  rsp_b_ff, rsp_b_in;
   count_type rsp_cnt_ff, rsp_cnt_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_done_ff, rsp_done_in;
   logic      rsp_err_ff, rsp_err_in;
   word_type  rsp_cons_ff, rsp_cons_in;

   // history memory
   byte_type  hist_mem [WINDOW_DEPTH];

   // decode and handshake signals
   logic      accept;
   logic      rsp_free;
   exec_type  kind;
   logic      needs_rsp;
   logic      exec_go;
   off_type   off_cur;
   run_type   len_cur;
   word_type  remaining;
   run_type   run_n;
   word_type  cons_inc;
   logic [16:0] prod_inc;
   logic      prod_reach;
   logic      need_emit;
   logic      cons;
   logic      iss;
   logic      final_cons;
   byte_type  copy_byte;
   logic      mem_we;
   byte_type  mem_wd;
   logic [AW:0] rd_diff;
   ptr_type   rd_addr;

   // handshake
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // field decode of the held request
   assign off_cur   = {mfb_ff[1:0], b_ff};
   assign len_cur   = RUN_W'(mfb_ff[7:8-LEN_BITS]) + RUN_W'(LEN_BIAS);
   assign remaining = out_len_ff - produced_ff;
   assign run_n     = (remaining < 16'(len_cur)) ? remaining[RUN_W-1:0] : len_cur;
   assign cons_inc  = (consumed_ff == 16'hFFFF) ? consumed_ff : consumed_ff + 16'd1;
   assign prod_inc  = {1'b0, produced_ff} + 17'd1;
   assign prod_reach = (prod_inc >= {1'b0, out_len_ff});

   // classify the held request
   always_comb begin
      kind = EX_DROP;
      if (over_ff) begin
         kind = EX_DROP;
      end else if (produced_ff >= out_len_ff) begin
         kind = EX_LIMIT;
      end else begin
         unique case (phase_ff)
            PH_CONTROL: kind = EX_CONTROL;
            PH_TOKEN:   kind = ctrl_ff[bitpos_ff] ? EX_MATCH1 : EX_LITERAL;
            PH_MATCH2: begin
               if (off_cur == '0 || 16'(off_cur) > produced_ff) begin
                  kind = EX_BADOFF;
               end else begin
                  kind = EX_COPY;
               end
            end
            default:    kind = EX_DROP;
         endcase
      end
   end

   assign needs_rsp = (kind == EX_LIMIT) || (kind == EX_LITERAL) || (kind == EX_BADOFF);
   assign exec_go   = (state_ff == ST_EXEC) && (!needs_rsp || rsp_free);

   // copy pipeline: issue a read, then consume the returned byte
   assign need_emit  = pair_full_ff || (cnt_ff == RUN_W'(1));
   assign cons       = dv_ff && (!need_emit || rsp_free);
   assign final_cons = cons && (cnt_ff == RUN_W'(1));
   assign iss        = (state_ff == ST_COPY) && (iss_left_ff != '0) && (!dv_ff || cons);
   assign copy_byte  = fwd_ff ? fwd_data_ff : mem_q_ff;

   // history write port
   assign mem_we = (exec_go && kind == EX_LITERAL) || cons;
   assign mem_wd = (state_ff == ST_COPY) ? copy_byte : b_ff;

   // read address wraps back over the ring
   assign rd_diff = {1'b0, iss_ptr_ff} - (AW+1)'(off_ff);
   assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(WINDOW_DEPTH)) : rd_diff[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_go) state_in = (kind == EX_COPY) ? ST_COPY : ST_IDLE;
         end
         ST_COPY: if (final_cons) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in     = phase_ff;
      ctrl_in      = ctrl_ff;
      bitpos_in    = bitpos_ff;
      mfb_in       = mfb_ff;
      produced_in  = produced_ff;
      consumed_in  = consumed_ff;
      over_in      = over_ff;
      out_len_in   = csr_write_en ? csr_write_data : out_len_ff;
      wr_ptr_in    = wr_ptr_ff;
      iss_ptr_in   = iss_ptr_ff;
      iss_left_in  = iss_left_ff;
      cnt_in       = cnt_ff;
      pair_full_in = pair_full_ff;
      pair_byte_in = pair_byte_ff;
      b_in         = b_ff;
      off_in       = off_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      dv_in        = dv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_cons_in  = rsp_cons_ff;

      // take a request, a frame start clears the frame state
      if (accept) begin
         b_in = req_chan.in_byte;
         if (req_chan.frame_start) begin
            phase_in    = PH_CONTROL;
            ctrl_in     = '0;
            bitpos_in   = 3'd7;
            mfb_in      = '0;
            produced_in = '0;
            consumed_in = '0;
            over_in     = 1'b0;
            wr_ptr_in   = '0;
         end
      end

      // execute the held request
      if (exec_go && kind != EX_DROP) begin
         if (kind != EX_LIMIT) consumed_in = cons_inc;
         unique case (kind)
            EX_LIMIT: begin
               over_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_a_in     = '0;
               rsp_b_in     = '0;
               rsp_cnt_in   = 2'd0;
               rsp_last_in  = 1'b1;
               rsp_done_in  = 1'b1;
               rsp_err_in   = 1'b0;
               rsp_cons_in  = consumed_ff;
            end
            EX_CONTROL: begin
               ctrl_in   = b_ff;
               bitpos_in = 3'd0;
               phase_in  = PH_TOKEN;
            end
            EX_MATCH1: begin
               mfb_in   = b_ff;
               phase_in = PH_MATCH2;
            end
            EX_BADOFF: begin
               over_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_a_in     = '0;
               rsp_b_in     = '0;
               rsp_cnt_in   = 2'd0;
               rsp_last_in  = 1'b1;
               rsp_done_in  = 1'b0;
               rsp_err_in   = 1'b1;
               rsp_cons_in  = cons_inc;
            end
            default: begin
               // literal or match start: advance to the next token
               if (bitpos_ff == 3'd7) begin
                  phase_in = PH_CONTROL;
               end else begin
                  bitpos_in = bitpos_ff + 3'd1;
                  phase_in  = PH_TOKEN;
               end
               if (kind == EX_LITERAL) begin
                  over_in      = prod_reach;
                  rsp_valid_in = 1'b1;
                  rsp_a_in     = b_ff;
                  rsp_b_in     = '0;
                  rsp_cnt_in   = 2'd1;
                  rsp_last_in  = 1'b1;
                  rsp_done_in  = prod_reach;
                  rsp_err_in   = 1'b0;
                  rsp_cons_in  = prod_reach ? cons_inc : '0;
               end else begin
                  off_in       = off_cur;
                  iss_ptr_in   = wr_ptr_ff;
                  iss_left_in  = run_n;
                  cnt_in       = run_n;
                  pair_full_in = 1'b0;
               end
            end
         endcase
      end

      // issue one history read
      if (iss) begin
         iss_left_in = iss_left_ff - RUN_W'(1);
         iss_ptr_in  = (iss_ptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : iss_ptr_ff + AW'(1);
         fwd_in      = mem_we && (wr_ptr_ff == rd_addr);
         fwd_data_in = mem_wd;
         dv_in       = 1'b1;
      end else if (cons) begin
         dv_in = 1'b0;
      end

      // consume a copied byte, pair it up or emit a result
      if (cons) begin
         cnt_in = cnt_ff - RUN_W'(1);
         if (need_emit) begin
            pair_full_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_a_in     = pair_full_ff ? pair_byte_ff : copy_byte;
            rsp_b_in     = pair_full_ff ? copy_byte : '0;
            rsp_cnt_in   = pair_full_ff ? 2'd2 : 2'd1;
            rsp_last_in  = final_cons;
            rsp_done_in  = prod_reach;
            rsp_err_in   = 1'b0;
            rsp_cons_in  = prod_reach ? consumed_ff : '0;
         end else begin
            pair_full_in = 1'b1;
            pair_byte_in = copy_byte;
         end
         if (final_cons) over_in = prod_reach;
      end

      // history write advances the ring
      if (mem_we) begin
         produced_in = produced_ff + 16'd1;
         wr_ptr_in   = (wr_ptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CONTROL;
         ctrl_ff      <= '0;
         bitpos_ff    <= 3'd7;
         mfb_ff       <= '0;
         produced_ff  <= '0;
         consumed_ff  <= '0;
         over_ff      <= 1'b0;
         out_len_ff   <= OUT_LENGTH_RESET;
         wr_ptr_ff    <= '0;
         iss_ptr_ff   <= '0;
         iss_left_ff  <= '0;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         pair_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ctrl_ff      <= ctrl_in;
         bitpos_ff    <= bitpos_in;
         mfb_ff       <= mfb_in;
         produced_ff  <= produced_in;
         consumed_ff  <= consumed_in;
         over_ff      <= over_in;
         out_len_ff   <= out_len_in;
         wr_ptr_ff    <= wr_ptr_in;
         iss_ptr_ff   <= iss_ptr_in;
         iss_left_ff  <= iss_left_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         pair_full_ff <= pair_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      b_ff         <= b_in;
      off_ff       <= off_in;
      pair_byte_ff <= pair_byte_in;
      fwd_ff       <= fwd_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_cons_ff  <= rsp_cons_in;
   end

   // history memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[wr_ptr_ff] <= mem_wd;
      if (iss) mem_q_ff <= hist_mem[rd_addr];
   end

   // result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.byte_a         = rsp_a_ff;
   assign rsp_chan.byte_b         = rsp_b_ff;
   assign rsp_chan.byte_count     = rsp_cnt_ff;
   assign rsp_chan.last_of_run    = rsp_last_ff;
   assign rsp_chan.frame_done     = rsp_done_ff;
   assign rsp_chan.frame_error    = rsp_err_ff;
   assign rsp_chan.consumed_bytes = rsp_cons_ff;

endmodule

`default_nettype wire
